### sv/fpa_pkg.sv
// Shared types, opcodes and saturation helpers for the fixed-point ALU.
// No dependencies; every other file in sv/ refers to this package.
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int NQ_DEF        = 32 + FRAC_BITS_DEF;   // quotient bits at the default

  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_INC = 4'd4,
    OP_DEC = 4'd5,
    OP_MAX = 4'd6,
    OP_MIN = 4'd7,
    OP_I2F = 4'd8,
    OP_F2I = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]          opcode;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]  result;
    logic                a_greater;
    logic                a_less;
    logic                operands_equal;
    logic                overflow;
    logic                divide_by_zero;
  } out_word_t;

  // sideband that rides along the pipeline with each word
  typedef struct packed {
    logic [3:0]  op;
    logic        neg;     // sign of the mul/div result
    logic [31:0] res;
    logic        ovf;
    logic        dz;
    logic        gt;
    logic        lt;
    logic        eq;
  } side_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] res;
  } sat_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic sat_t sat_s33(input logic signed [32:0] v);
    sat_t s;
    s.ovf = v[32] ^ v[31];
    s.res = s.ovf ? (v[32] ? MIN_NEG : MAX_POS) : v[31:0];
    return s;
  endfunction

  // saturate a sign/magnitude value to 32 bits
  function automatic sat_t sat_sm(input logic neg, input logic [63:0] mag);
    sat_t        s;
    logic [63:0] lim;
    logic [63:0] ng;
    lim   = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    ng    = 64'd0 - mag;
    s.ovf = mag > lim;
    if (s.ovf) begin
      s.res = neg ? MIN_NEG : MAX_POS;
    end else begin
      s.res = neg ? ng[31:0] : mag[31:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/fixed_point_alu_unit.sv
// Fixed-point ALU: signed 32-bit values with FRAC_BITS fraction bits.
// Input channel in_valid/in_stall/in_word carries opcode and two raw operands;
// output channel out_valid/out_stall/out_word carries result plus compare,
// overflow and divide-by-zero flags. A word moves when valid is high and
// stall is low.
// Path from input accept to output valid: three front stages (decode,
// 32x32 multiply, multiply rounding), 32 + FRAC_BITS restoring-division
// stages of one quotient bit each, and the output register. Every opcode
// takes the same path length.
// Throughput: one word per cycle while the output is not stalled.
// Stall: the whole pipeline freezes while the output register holds a word
// the receiver is stalling; in_stall rises in the same cycle. Empty slots
// do not collapse. Reset clears only the valid bits; the pipe is empty after.
// Depends on fpa_pkg, fpa_front, fpa_div_stage, fpa_back.
`default_nettype none
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpa_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpa_pkg::out_word_t      out_word
);

  localparam int NQ = 32 + FRAC_BITS;   // quotient bits = division stages

  // pipeline advances unless a held output word is stalled
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // division chain taps: index 0 is the front-end output
  logic                 v_c   [NQ+1];
  fpa_pkg::side_t       s_c   [NQ+1];
  logic [31:0]          rem_c [NQ+1];
  logic [NQ-1:0]        nq_c  [NQ+1];
  logic [31:0]          d_c   [NQ+1];

  fpa_front #(.FRAC_BITS(FRAC_BITS), .NQ(NQ)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_valid),
    .word_in  (in_word),
    .v_out    (v_c[0]),
    .side_out (s_c[0]),
    .nq_out   (nq_c[0]),
    .d_out    (d_c[0])
  );
  assign rem_c[0] = '0;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    fpa_div_stage #(.NQ(NQ)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (v_c[i]),
      .side_in  (s_c[i]),
      .rem_in   (rem_c[i]),
      .nq_in    (nq_c[i]),
      .d_in     (d_c[i]),
      .v_out    (v_c[i+1]),
      .side_out (s_c[i+1]),
      .rem_out  (rem_c[i+1]),
      .nq_out   (nq_c[i+1]),
      .d_out    (d_c[i+1])
    );
  end

  fpa_back #(.NQ(NQ)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v_c[NQ]),
    .side_in  (s_c[NQ]),
    .rem_in   (rem_c[NQ]),
    .nq_in    (nq_c[NQ]),
    .d_in     (d_c[NQ]),
    .v_out    (out_valid),
    .word_out (out_word)
  );

`ifndef SYNTH
  // exactly one compare relation holds
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_word.a_greater, out_word.a_less, out_word.operands_equal}))
    else $error("compare flags not one-hot");

  // divide by zero never also reports overflow
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.divide_by_zero |-> !out_word.overflow)
    else $error("divide_by_zero with overflow");

  // a saturated result sits on a range bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.overflow |->
      (out_word.result == fpa_pkg::MAX_POS) || (out_word.result == fpa_pkg::MIN_NEG))
    else $error("overflow result not at bound");
`endif

endmodule
`default_nettype wire

### sv/fpa_front.sv
// Front end: decode and simple ops, 32x32 multiply, multiply rounding.
// Three register stages; depends on fpa_pkg.
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int NQ        = 32 + FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               v_in,
  input  wire fpa_pkg::in_word_t  word_in,
  output logic                    v_out,
  output fpa_pkg::side_t          side_out,
  output logic [NQ-1:0]           nq_out,
  output logic [31:0]             d_out
);

  // stage 1: decode
  logic signed [31:0] a, b;
  logic [31:0]        a_mag, b_mag;
  logic [NQ-1:0]      a_shl;
  fpa_pkg::side_t     s1_nxt;
  fpa_pkg::sat_t      sat;

  logic               v1_r, v2_r, v3_r;
  fpa_pkg::side_t     s1_r, s2_r, s3_r;
  logic [31:0]        am1_r, bm1_r, am2_r, bm2_r, am3_r, bm3_r;
  logic [63:0]        prod_r;

  always_comb begin
    a      = word_in.operand_a;
    b      = word_in.operand_b;
    a_mag  = a[31] ? (32'd0 - a) : a;
    b_mag  = b[31] ? (32'd0 - b) : b;
    a_shl  = NQ'(a_mag) << FRAC_BITS;
    sat    = '0;
    s1_nxt = '0;
    s1_nxt.op  = word_in.opcode;
    s1_nxt.neg = a[31] ^ b[31];
    s1_nxt.gt  = a > b;
    s1_nxt.lt  = a < b;
    s1_nxt.eq  = a == b;
    case (fpa_pkg::op_t'(word_in.opcode))
      fpa_pkg::OP_ADD: sat = fpa_pkg::sat_s33(33'(a) + 33'(b));
      fpa_pkg::OP_SUB: sat = fpa_pkg::sat_s33(33'(a) - 33'(b));
      fpa_pkg::OP_INC: sat = fpa_pkg::sat_s33(33'(a) + 33'sd1);
      fpa_pkg::OP_DEC: sat = fpa_pkg::sat_s33(33'(a) - 33'sd1);
      fpa_pkg::OP_MAX: sat.res = (a > b) ? a : b;
      fpa_pkg::OP_MIN: sat.res = (a < b) ? a : b;
      fpa_pkg::OP_I2F: sat = fpa_pkg::sat_sm(a[31], 64'(a_shl));
      fpa_pkg::OP_F2I: sat.res = a >>> FRAC_BITS;
      fpa_pkg::OP_DIV: begin
        if (b == 32'sd0) begin
          s1_nxt.dz = 1'b1;
          sat.res   = a[31] ? fpa_pkg::MIN_NEG : ((a == 32'sd0) ? 32'd0 : fpa_pkg::MAX_POS);
        end
      end
      default: sat = '0;
    endcase
    s1_nxt.res = sat.res;
    s1_nxt.ovf = sat.ovf;
  end

  // stage 3: multiply rounding, ties away from zero on the magnitude
  logic [63:0]    q_mul;
  logic           rnd;
  fpa_pkg::side_t s3_nxt;
  fpa_pkg::sat_t  msat;

  always_comb begin
    rnd    = (FRAC_BITS > 0) ? prod_r[(FRAC_BITS > 0) ? FRAC_BITS - 1 : 0] : 1'b0;
    q_mul  = (prod_r >> FRAC_BITS) + 64'(rnd);
    msat   = fpa_pkg::sat_sm(s2_r.neg, q_mul);
    s3_nxt = s2_r;
    if (fpa_pkg::op_t'(s2_r.op) == fpa_pkg::OP_MUL) begin
      s3_nxt.res = msat.res;
      s3_nxt.ovf = msat.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= s1_nxt;
      am1_r  <= a_mag;
      bm1_r  <= b_mag;
      s2_r   <= s1_r;
      am2_r  <= am1_r;
      bm2_r  <= bm1_r;
      prod_r <= 64'(am1_r) * 64'(bm1_r);
      s3_r   <= s3_nxt;
      am3_r  <= am2_r;
      bm3_r  <= bm2_r;
    end
  end

  assign v_out    = v3_r;
  assign side_out = s3_r;
  assign nq_out   = NQ'(am3_r) << FRAC_BITS;
  assign d_out    = bm3_r;

endmodule
`default_nettype wire

### sv/fpa_div_stage.sv
// One restoring-division stage: develops one quotient bit per word.
// Depends on fpa_pkg for the sideband type.
`default_nettype none
module fpa_div_stage #(
  parameter int NQ = fpa_pkg::NQ_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire fpa_pkg::side_t  side_in,
  input  wire logic [31:0]     rem_in,
  input  wire logic [NQ-1:0]   nq_in,
  input  wire logic [31:0]     d_in,
  output logic                 v_out,
  output fpa_pkg::side_t       side_out,
  output logic [31:0]          rem_out,
  output logic [NQ-1:0]        nq_out,
  output logic [31:0]          d_out
);

  logic [32:0]    t, diff;
  logic           ge;
  logic           v_r;
  fpa_pkg::side_t side_r;
  logic [31:0]    rem_r, d_r;
  logic [NQ-1:0]  nq_r;

  // dividend bits shift out the top of nq, quotient bits enter at the bottom
  always_comb begin
    t    = {rem_in, nq_in[NQ-1]};
    diff = t - {1'b0, d_in};
    ge   = t >= {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      rem_r  <= ge ? diff[31:0] : t[31:0];
      nq_r   <= {nq_in[NQ-2:0], ge};
      d_r    <= d_in;
    end
  end

  assign v_out    = v_r;
  assign side_out = side_r;
  assign rem_out  = rem_r;
  assign nq_out   = nq_r;
  assign d_out    = d_r;

endmodule
`default_nettype wire

### sv/fpa_back.sv
// Back end: division rounding and saturation, then the output register.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back #(
  parameter int NQ = fpa_pkg::NQ_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire fpa_pkg::side_t  side_in,
  input  wire logic [31:0]     rem_in,
  input  wire logic [NQ-1:0]   nq_in,
  input  wire logic [31:0]     d_in,
  output logic                 v_out,
  output fpa_pkg::out_word_t   word_out
);

  logic [NQ:0]            q_rnd;
  fpa_pkg::sat_t          dsat;
  fpa_pkg::out_word_t     word_nxt;
  logic                   v_r;
  fpa_pkg::out_word_t     word_r;

  always_comb begin
    q_rnd = (NQ+1)'(nq_in) + (NQ+1)'({rem_in, 1'b0} >= {1'b0, d_in});
    dsat  = fpa_pkg::sat_sm(side_in.neg, 64'(q_rnd));
    word_nxt.result         = side_in.res;
    word_nxt.overflow       = side_in.ovf;
    word_nxt.a_greater      = side_in.gt;
    word_nxt.a_less         = side_in.lt;
    word_nxt.operands_equal = side_in.eq;
    word_nxt.divide_by_zero = side_in.dz;
    if (fpa_pkg::op_t'(side_in.op) == fpa_pkg::OP_DIV && !side_in.dz) begin
      word_nxt.result   = dsat.res;
      word_nxt.overflow = dsat.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign v_out    = v_r;
  assign word_out = word_r;

endmodule
`default_nettype wire

### tb/sv/fixed_point_alu_unit_test.sv
// Testbench for fixed_point_alu_unit: directed table then random words, each result
// checked against a local integer-exact predictor. Depends on fpa_pkg and the RTL.
`timescale 1ns / 100ps
module fixed_point_alu_unit_test;

  localparam int FB = fpa_pkg::FRAC_BITS_DEF;
  localparam int N_RANDOM = 1880;
  localparam int LATENCY = 36 + FB;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fpa_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fpa_pkg::out_word_t out_word;

  fpa_pkg::out_word_t expected_q[$];
  int errors = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;   // set by the sender to request one long receiver stall
  int seen = 0;

  // directed rows; has_exp marks rows whose result is typed in by hand
  typedef struct packed {
    logic [3:0] opcode;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic has_exp;
    fpa_pkg::out_word_t exp;
  } dir_row_t;

  always #10 clk = ~clk;

  fixed_point_alu_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // sign/magnitude to 32 bits with saturation
  function automatic logic [32:0] clamp_sm(input bit neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(64'd0 - mag)};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // exact result of one ALU word
  function automatic fpa_pkg::out_word_t alu_result(input fpa_pkg::in_word_t w);
    fpa_pkg::out_word_t r;
    longint a, b;
    logic [63:0] p, q, n, d, rm;
    logic [32:0] s;
    a = longint'(w.operand_a);
    b = longint'(w.operand_b);
    r = '0;
    s = '0;
    case (w.opcode)
      fpa_pkg::OP_ADD: s = clamp_sm(a + b < 0, magnitude(a + b));
      fpa_pkg::OP_SUB: s = clamp_sm(a - b < 0, magnitude(a - b));
      fpa_pkg::OP_INC: s = clamp_sm(a + 1 < 0, magnitude(a + 1));
      fpa_pkg::OP_DEC: s = clamp_sm(a - 1 < 0, magnitude(a - 1));
      fpa_pkg::OP_MUL: begin
        p = magnitude(a) * magnitude(b);
        q = p >> FB;
        if (FB > 0 && p[(FB > 0 ? FB - 1 : 0)]) q++;
        s = clamp_sm((a < 0) != (b < 0), q);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
          s = {1'b0, a > 0 ? fpa_pkg::MAX_POS : (a < 0 ? fpa_pkg::MIN_NEG : 32'd0)};
        end else begin
          n = magnitude(a) << FB;
          d = magnitude(b);
          q = n / d;
          rm = n % d;
          if (2 * rm >= d) q++;
          s = clamp_sm((a < 0) != (b < 0), q);
        end
      end
      fpa_pkg::OP_MAX: s = {1'b0, a > b ? w.operand_a : w.operand_b};
      fpa_pkg::OP_MIN: s = {1'b0, a < b ? w.operand_a : w.operand_b};
      fpa_pkg::OP_I2F: s = clamp_sm(a < 0, magnitude(a) << FB);
      fpa_pkg::OP_F2I: s = {1'b0, 32'(a >>> FB)};
      default: s = '0;
    endcase
    r.result = s[31:0];
    r.overflow = s[32];
    r.a_greater = a > b;
    r.a_less = a < b;
    r.operands_equal = a == b;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch on word %0d: %s got %0h expected %0h", seen, what, got, exp);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 600)) - 300;
      3: return 32'($urandom_range(0, 1) ? 1 : -1) * 32'($urandom_range(0, 1 << 16));
      4: return '0;
      default: return $urandom();
    endcase
  endfunction

  // offer one word after an optional idle gap, hold it until accepted
  task automatic send_word(input fpa_pkg::in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(alu_result(w));
  endtask

  // row helper: expected compare flags computed from the operands for hand-typed results
  function automatic dir_row_t row(input fpa_pkg::op_t op, input logic [31:0] a,
                                   input logic [31:0] b,
                                   input bit has_exp = 0, input logic [31:0] res = 0,
                                   input bit ovf = 0, input bit dz = 0);
    dir_row_t d;
    d.opcode = op;
    d.a = a;
    d.b = b;
    d.has_exp = has_exp;
    d.exp.result = res;
    d.exp.a_greater = $signed(a) > $signed(b);
    d.exp.a_less = $signed(a) < $signed(b);
    d.exp.operands_equal = a == b;
    d.exp.overflow = ovf;
    d.exp.divide_by_zero = dz;
    return d;
  endfunction

  dir_row_t dir_table[$];
  fpa_pkg::out_word_t typed_q[$];   // hand-typed results, checked besides the predictor
  bit typed_flag_q[$];

  initial begin
    fpa_pkg::in_word_t w;
    dir_table = '{
      row(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 1, fpa_pkg::MAX_POS, 1),
      row(fpa_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 1, fpa_pkg::MAX_POS, 1),
      row(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, fpa_pkg::MAX_POS, 1),
      row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_MUL, 32'h0000_0180, 32'h0000_0001),
      row(fpa_pkg::OP_MUL, 32'hFFFF_FE80, 32'h0000_0001),
      row(fpa_pkg::OP_DIV, 32'd5, 32'd0, 1, fpa_pkg::MAX_POS, 0, 1),
      row(fpa_pkg::OP_DIV, 32'hFFFF_FFFB, 32'd0, 1, fpa_pkg::MIN_NEG, 0, 1),
      row(fpa_pkg::OP_DIV, 32'd0, 32'd0, 1, 32'd0, 0, 1),
      row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'd1, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_DIV, 32'd1, 32'd3),
      row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF),
      row(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'd0, 1, fpa_pkg::MAX_POS, 1),
      row(fpa_pkg::OP_DEC, 32'h8000_0000, 32'd0, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, fpa_pkg::MAX_POS),
      row(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, fpa_pkg::MIN_NEG),
      row(fpa_pkg::OP_MAX, 32'd7, 32'd7, 1, 32'd7),
      row(fpa_pkg::OP_I2F, 32'h7FFF_FFFF, 32'd0, 1, fpa_pkg::MAX_POS, 1),
      row(fpa_pkg::OP_I2F, 32'h8000_0000, 32'd0, 1, fpa_pkg::MIN_NEG, 1),
      row(fpa_pkg::OP_F2I, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF),
      row(fpa_pkg::OP_F2I, 32'h7FFF_FFFF, 32'd0),
      row(fpa_pkg::op_t'(4'd15), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0),
      row(fpa_pkg::op_t'(4'd10), 32'd3, 32'd9, 1, 32'd0)
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_table[i]) begin
      w.opcode = dir_table[i].opcode;
      w.operand_a = dir_table[i].a;
      w.operand_b = dir_table[i].b;
      typed_flag_q.push_back(dir_table[i].has_exp);
      typed_q.push_back(dir_table[i].exp);
      send_word(w);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off = 1'b1;
      w.opcode = $urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
      w.operand_a = rand_operand();
      w.operand_b = $urandom_range(0, 15) == 0 ? 32'd0 : rand_operand();
      send_word(w);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall; one long hold-off lets the pipe fill and push back
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end
      n = gap_len();
      out_stall <= n > 0;
      repeat (n > 0 ? n - 1 : 0) @(posedge clk);
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    fpa_pkg::out_word_t e;
    fpa_pkg::out_word_t t;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_word, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_word.result !== e.result) report_mismatch("result", out_word.result, e.result);
        if (out_word.a_greater !== e.a_greater)
          report_mismatch("a_greater", out_word.a_greater, e.a_greater);
        if (out_word.a_less !== e.a_less) report_mismatch("a_less", out_word.a_less, e.a_less);
        if (out_word.operands_equal !== e.operands_equal)
          report_mismatch("operands_equal", out_word.operands_equal, e.operands_equal);
        if (out_word.overflow !== e.overflow)
          report_mismatch("overflow", out_word.overflow, e.overflow);
        if (out_word.divide_by_zero !== e.divide_by_zero)
          report_mismatch("divide_by_zero", out_word.divide_by_zero, e.divide_by_zero);
        if (typed_q.size() > 0) begin
          t = typed_q.pop_front();
          if (typed_flag_q.pop_front() && out_word !== t)
            report_mismatch("directed word", out_word, t);
        end
      end
      seen++;
    end
  end

  // end of run and watchdog
  initial begin
    while (!(stim_done && expected_q.size() == 0) && cycles < CYCLE_LIMIT) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
    end else begin
      repeat (LATENCY + 20) @(posedge clk);
      if (errors == 0 && expected_q.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

endmodule
